### hdl/tcef_pkg.sv
package tcef_pkg;

	localparam int TIME_W = 32;
	localparam int DUR_W  = 16;
	localparam int LVL_W  = 8;
	localparam int Q_W    = 16;
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic [DUR_W-1:0] DURATION_RESET = 16'd1000;

	// 1.0 and 3.0 in Q.16, sized for the multiplier operand.
	localparam logic [MUL_W-1:0] Q_ONE   = 18'h1_0000;
	localparam logic [MUL_W-1:0] K_THREE = 18'h3_0000;

	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [TIME_W-1:0] now_ms;
		logic [LVL_W-1:0]  target_warm;
		logic [LVL_W-1:0]  target_cool;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0] warm_level;
		logic [LVL_W-1:0] cool_level;
		logic             fading;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [Q_W-1:0]   num;
		logic [DUR_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] quot;
	} div_rsp_t;

endpackage

### hdl/two_channel_eased_fade_top.sv
// Channel   Handshake                Payload                 Direction
// item      item_valid / item_stall  item (tcef_pkg::item_t)  into block
// result    result_valid/result_stall result (result_t)       out of block
// cfg       cfg_valid / cfg_ready    cfg_data (duration, ms)  into block
//
// A set-target transaction or a tick that does not interpolate goes straight to the
// S_DONE state and is loaded into the result register from there; an interpolating tick
// first runs the serial divider, then five shared multiplier passes, then S_LAST.
// item_stall is high from acceptance until the result is loaded, which waits while a
// stalled sink still holds the previous result.
// Asynchronous reset clears all fade state and sets the duration to 1000 ms.
module two_channel_eased_fade_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  tcef_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output tcef_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcef_pkg::DUR_W-1:0]    cfg_data
);

	localparam int LW = tcef_pkg::LVL_W;
	localparam int QW = tcef_pkg::Q_W;

	// Sequencer codes.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_T2   = 4'd2;
	localparam logic [3:0] S_S    = 4'd3;
	localparam logic [3:0] S_E    = 4'd4;
	localparam logic [3:0] S_W    = 4'd5;
	localparam logic [3:0] S_C    = 4'd6;
	localparam logic [3:0] S_LAST = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]                        state_q;
	logic [tcef_pkg::DUR_W-1:0]        dur_q;
	logic [LW-1:0]                     from_warm_q, from_cool_q;
	logic [LW-1:0]                     goal_warm_q, goal_cool_q;
	logic [LW-1:0]                     level_warm_q, level_cool_q;
	logic                              dimming_q, running_q;
	logic [tcef_pkg::TIME_W-1:0]       begin_stamp_q;
	logic [QW-1:0]                     e_q;
	tcef_pkg::result_t                 result_q;
	logic                              result_valid_q;

	logic                              accept;
	logic                              slot_free;
	logic [tcef_pkg::TIME_W-1:0]       elapsed;
	logic                              fade_over;
	logic [LW:0]                       cur_sum, new_sum;
	logic [LW-1:0]                     mag_warm, mag_cool;
	logic [QW-1:0]                     p_hi;
	logic [tcef_pkg::MUL_W-1:0]        mul_a, mul_b;
	logic [tcef_pkg::PROD_W-1:0]       prod;
	tcef_pkg::div_req_t                div_req;
	tcef_pkg::div_rsp_t                div_rsp;

	// Moves a level from its start toward its goal by mag * e / 2^16, where the
	// product has already been formed and registered by the shared multiplier.
	function automatic logic [LW-1:0] blend(input logic [LW-1:0] from,
			input logic [LW-1:0] goal, input logic [LW-1:0] step);
		logic [LW-1:0] r;
		if (goal >= from) begin
			r = from + step;
		end else begin
			r = from - step;
		end
		return r;
	endfunction

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign slot_free  = !result_valid_q || !result_stall;
	assign cfg_ready  = 1'b1;

	// Elapsed time wraps at 32 bits; anything at or past the duration ends it.
	assign elapsed   = item.now_ms - begin_stamp_q;
	assign fade_over = elapsed >= {{(tcef_pkg::TIME_W - tcef_pkg::DUR_W){1'b0}}, dur_q};

	assign cur_sum = {1'b0, level_warm_q} + {1'b0, level_cool_q};
	assign new_sum = {1'b0, item.target_warm} + {1'b0, item.target_cool};

	assign mag_warm = (goal_warm_q >= from_warm_q) ? goal_warm_q - from_warm_q
	                                               : from_warm_q - goal_warm_q;
	assign mag_cool = (goal_cool_q >= from_cool_q) ? goal_cool_q - from_cool_q
	                                               : from_cool_q - goal_cool_q;

	// Upper half of the Q.16 product: the value scaled back down by 2^16.
	assign p_hi = prod[2*QW-1:QW];

	// The divider only runs when elapsed < duration, so elapsed fits in 16 bits
	// and the quotient is the fade position t in Q0.16.
	assign div_req.start = accept && (item.kind == tcef_pkg::KIND_TICK) && running_q
	                       && !fade_over;
	assign div_req.num   = elapsed[QW-1:0];
	assign div_req.den   = dur_q;

	tcef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Operand selection for the shared multiplier. Each step after t * t reads a product
	// registered by an earlier step; S_C reads it through e_q.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_T2: begin
				// t * t
				mul_a = {2'b00, div_rsp.quot};
				mul_b = {2'b00, div_rsp.quot};
			end
			S_S: begin
				// t2 * (3 - 2t)
				mul_a = {2'b00, p_hi};
				mul_b = tcef_pkg::K_THREE - {1'b0, div_rsp.quot, 1'b0};
			end
			S_E: begin
				// Dimming squares the smoothstep; rising multiplies it by one.
				mul_a = {2'b00, p_hi};
				mul_b = dimming_q ? {2'b00, p_hi} : tcef_pkg::Q_ONE;
			end
			S_W: begin
				mul_a = {2'b00, p_hi};
				mul_b = {{(tcef_pkg::MUL_W - LW){1'b0}}, mag_warm};
			end
			S_C: begin
				mul_a = {2'b00, e_q};
				mul_b = {{(tcef_pkg::MUL_W - LW){1'b0}}, mag_cool};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	tcef_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Configuration register. The user must write only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= tcef_pkg::DURATION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dur_q <= cfg_data;
		end
	end

	// Fade state and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			from_warm_q   <= '0;
			from_cool_q   <= '0;
			goal_warm_q   <= '0;
			goal_cool_q   <= '0;
			level_warm_q  <= '0;
			level_cool_q  <= '0;
			dimming_q     <= 1'b0;
			running_q     <= 1'b0;
			begin_stamp_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.kind == tcef_pkg::KIND_SET) begin
							// Latch the present levels as the start of a new fade.
							dimming_q     <= new_sum < cur_sum;
							from_warm_q   <= level_warm_q;
							from_cool_q   <= level_cool_q;
							goal_warm_q   <= item.target_warm;
							goal_cool_q   <= item.target_cool;
							begin_stamp_q <= item.now_ms;
							if (dur_q == '0) begin
								level_warm_q <= item.target_warm;
								level_cool_q <= item.target_cool;
								running_q    <= 1'b0;
							end else begin
								running_q <= 1'b1;
							end
							state_q <= S_DONE;
						end else if (!running_q) begin
							state_q <= S_DONE;
						end else if (fade_over) begin
							level_warm_q <= goal_warm_q;
							level_cool_q <= goal_cool_q;
							running_q    <= 1'b0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_T2;
					end
				end
				S_T2: state_q <= S_S;
				S_S:  state_q <= S_E;
				S_E:  state_q <= S_W;
				S_W: begin
					state_q <= S_C;
				end
				S_C: begin
					level_warm_q <= blend(from_warm_q, goal_warm_q, prod[QW+LW-1:QW]);
					state_q      <= S_LAST;
				end
				S_LAST: begin
					level_cool_q <= blend(from_cool_q, goal_cool_q, prod[QW+LW-1:QW]);
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The eased position is needed for both channels, so it is held here.
	always_ff @(posedge clk) begin
		if (state_q == S_W) begin
			e_q <= p_hi;
		end
	end

	// Output register: holds a finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && slot_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			result_q.warm_level <= level_warm_q;
			result_q.cool_level <= level_cool_q;
			result_q.fading     <= running_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// A result only appears after the sequencer has passed through its final step.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished transaction");

	// Interpolation only happens while a fade runs.
	a_div_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> running_q)
		else $error("divider in use with no fade running");

	// The divider hands over to the multiplier steps as soon as it finishes.
	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_rsp.done) |=> (state_q == S_T2))
		else $error("sequencer missed divider completion");
`endif

endmodule

### hdl/tcef_div.sv
// Restoring divider producing floor(num * 2^16 / den) for num < den, one
// quotient bit per cycle.
module tcef_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tcef_pkg::div_req_t req,
	output tcef_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(tcef_pkg::Q_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tcef_pkg::Q_W - 1);

	logic [tcef_pkg::Q_W-1:0]   rem_q;
	logic [tcef_pkg::Q_W-1:0]   quot_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [tcef_pkg::Q_W:0]     rem_sh;
	logic [tcef_pkg::Q_W:0]     rem_sub;
	logic                       ge;

	assign rem_sh  = {rem_q, 1'b0};
	assign ge      = rem_sh >= {1'b0, req.den};
	assign rem_sub = rem_sh - {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[tcef_pkg::Q_W-1:0] : rem_sh[tcef_pkg::Q_W-1:0];
			quot_q <= {quot_q[tcef_pkg::Q_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### hdl/tcef_mul.sv
// Shared unsigned multiplier with a registered product.
module tcef_mul (
	input  logic                          clk,
	input  logic [tcef_pkg::MUL_W-1:0]    a,
	input  logic [tcef_pkg::MUL_W-1:0]    b,
	output logic [tcef_pkg::PROD_W-1:0]   p
);

	logic [tcef_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule
